// ===== hw/rtl/tket_pkg.sv =====
// Package with the word types, status codes and control structs of the timer keyed entry table.
package tket_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam logic       OP_ADD    = 1'b0;
  localparam logic       OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [63:0] peer;
    logic [7:0]  level;
    logic [15:0] bucket;
    logic [31:0] fingerprint;
    logic [63:0] timer;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_peer;
    logic [7:0]  out_level;
    logic [15:0] out_bucket;
    logic [31:0] out_fingerprint;
    logic [63:0] out_timer;
  } res_t;

  typedef struct packed {
    logic [63:0] peer;
    logic [7:0]  level;
    logic [15:0] bucket;
    logic [31:0] fingerprint;
    logic [63:0] timer;
  } record_t;

  typedef enum logic [1:0] {
    RES_FULL,
    RES_NOT_FOUND,
    RES_ADDED,
    RES_REMOVED
  } res_kind_t;

  typedef struct packed {
    logic      latch;
    logic      add_write;
    logic      shift_write;
    logic      rd_en;
    logic      rd_next;
    logic      idx_clr;
    logic      idx_inc;
    logic      count_dec;
    logic      res_load;
    res_kind_t res_kind;
    logic      emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_add;
    logic full;
    logic match;
    logic idx_in;
    logic next_in;
  } ctl_status_t;

endpackage

// ===== hw/rtl/tket_datapath.sv =====
// Datapath of the timer keyed entry table: record memory, count, index and result register.
module tket_datapath import tket_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        request,
  input  ctl_cmd_t    cmd,
  output ctl_status_t stat,
  output res_t        result,
  output logic        done
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  record_t mem [TABLE_DEPTH];
  record_t rdata;
  req_t    req;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_plus;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  record_t wr_data;
  res_t result_next;

  assign idx_plus = idx + CNT_W'(1);

  assign stat.is_add  = (req.operation == OP_ADD);
  assign stat.full    = (count == CNT_W'(TABLE_DEPTH));
  assign stat.match   = (rdata.timer == req.timer);
  assign stat.idx_in  = (idx < count);
  assign stat.next_in = (idx_plus < count);

  assign rd_addr = cmd.rd_next ? idx_plus[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign wr_addr = cmd.add_write ? count[ADDR_W-1:0] : idx[ADDR_W-1:0];

  always_comb begin
    if (cmd.add_write) begin
      wr_data = '{peer: req.peer, level: req.level, bucket: req.bucket,
                  fingerprint: req.fingerprint, timer: req.timer};
    end else begin
      wr_data = rdata;
    end
  end

  always_comb begin
    result_next = '0;
    unique case (cmd.res_kind)
      RES_FULL: begin
        result_next.status = ST_FULL;
      end
      RES_NOT_FOUND: begin
        result_next.status = ST_NOT_FOUND;
      end
      RES_ADDED: begin
        result_next.status    = ST_OK;
        result_next.out_timer = req.timer;
      end
      RES_REMOVED: begin
        result_next.status          = ST_OK;
        result_next.out_peer        = rdata.peer;
        result_next.out_level       = rdata.level;
        result_next.out_bucket      = rdata.bucket;
        result_next.out_fingerprint = rdata.fingerprint;
        result_next.out_timer       = rdata.timer;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.add_write || cmd.shift_write) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
    if (cmd.res_load) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.add_write) begin
        count <= count + CNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx_plus;
      end
    end
  end

endmodule

// ===== hw/rtl/tket_ctrl.sv =====
// Controller state machine of the timer keyed entry table: add, scan and compaction sequencing.
module tket_ctrl import tket_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  ctl_status_t stat,
  output ctl_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN_ISSUE,
    S_SCAN_CHECK,
    S_SHIFT_ISSUE,
    S_SHIFT_WRITE
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_kind = RES_FULL;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_ADD;
        end
      end
      S_ADD: begin
        // The operation bit is taken from the latched word here.
        if (!stat.is_add) begin
          state_next = S_SCAN_ISSUE;
        end else begin
          cmd.res_load = 1'b1;
          cmd.emit     = 1'b1;
          if (stat.full) begin
            cmd.res_kind = RES_FULL;
          end else begin
            cmd.res_kind  = RES_ADDED;
            cmd.add_write = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_SCAN_ISSUE: begin
        if (stat.idx_in) begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_CHECK;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_NOT_FOUND;
          cmd.emit     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN_CHECK: begin
        if (stat.match) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_REMOVED;
          state_next   = S_SHIFT_ISSUE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_ISSUE;
        end
      end
      S_SHIFT_ISSUE: begin
        if (stat.next_in) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WRITE;
        end else begin
          cmd.count_dec = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SHIFT_WRITE: begin
        cmd.shift_write = 1'b1;
        cmd.idx_inc     = 1'b1;
        state_next      = S_SHIFT_ISSUE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/timer_keyed_entry_table.sv =====
// Top level of the timer keyed entry table: an ordered table of expiry records.
//
//   channel   signals                 handshake
//   ------------------------------------------------------------
//   command   start, busy, request    word taken when start && !busy
//   result    done, result            word valid for one cycle with done
//
// An add is answered from the S_ADD state after acceptance. A remove scans
// the records in order, reading and checking one at a time up to the
// match, then reads each later record and writes it down one place,
// through the single read port of the record memory. Reset clears the
// record count and the controller; the memory holds no reset value.
// The receiver cannot stall; busy holds off new words during the work.
module timer_keyed_entry_table import tket_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  ctl_cmd_t    cmd;
  ctl_status_t stat;
  ctl_cmd_t    cmd_fixed;

  always_comb begin
    cmd_fixed = cmd;
  end

  tket_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tket_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd_fixed),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

// ===== hw/rtl/tket_checker.sv =====
// Port-level assertions for the timer keyed entry table and their bind statement.
module tket_checker import tket_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t request,
  input logic done,
  input res_t result
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted word");

  a_no_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done)
    else $error("result word in the cycle after acceptance");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result words in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_NOT_FOUND ||
              result.status == ST_FULL))
    else $error("result status is not a known code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.out_timer == '0 &&
      result.out_peer == '0 && result.out_fingerprint == '0)
    else $error("failed result word carries nonzero fields");

endmodule

bind timer_keyed_entry_table tket_checker u_tket_checker (.*);

// ===== tb/timer_keyed_entry_table_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each result word of the timer keyed entry table and compares it.
module timer_keyed_entry_table_checker import tket_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic done,
  input  res_t result,
  output int   fail_count,
  output int   pending
);

  record_t records [TABLE_DEPTH];
  int      record_count;
  res_t    expected_q [$];

  function automatic res_t apply_word(req_t w);
    res_t r;
    int   hit;
    r   = '0;
    hit = -1;
    if (w.operation == OP_ADD) begin
      if (record_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        records[record_count] = record_t'({w.peer, w.level, w.bucket, w.fingerprint, w.timer});
        record_count++;
        r.status    = ST_OK;
        r.out_timer = w.timer;
      end
    end else begin
      for (int i = 0; i < record_count; i++) begin
        if (hit < 0 && records[i].timer == w.timer) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.status          = ST_OK;
        r.out_peer        = records[hit].peer;
        r.out_level       = records[hit].level;
        r.out_bucket      = records[hit].bucket;
        r.out_fingerprint = records[hit].fingerprint;
        r.out_timer       = records[hit].timer;
        for (int k = hit; k < record_count - 1; k++) records[k] = records[k + 1];
        record_count--;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (rst) begin
      record_count = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("status", 64'(exp_r.status), 64'(result.status));
          check_field("out_peer", exp_r.out_peer, result.out_peer);
          check_field("out_level", 64'(exp_r.out_level), 64'(result.out_level));
          check_field("out_bucket", 64'(exp_r.out_bucket), 64'(result.out_bucket));
          check_field("out_fingerprint", 64'(exp_r.out_fingerprint),
                      64'(result.out_fingerprint));
          check_field("out_timer", exp_r.out_timer, result.out_timer);
        end
      end
      if (start && !busy) expected_q.push_back(apply_word(request));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/timer_keyed_entry_table_tb.sv =====
`timescale 1ns / 1ps
// Top of the timer keyed entry table testbench: clock, reset, command stimulus and verdict.
module timer_keyed_entry_table_tb import tket_pkg::*;;

  localparam int ITEM_TOTAL  = 1600;
  localparam int STALL_LIMIT = 4000;
  localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_CDEF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  res_t result;
  int   fail_count;
  int   pending;

  logic [63:0] key_pool [16];
  int          sent;
  int          burst_left;
  int          idle_cycles;

  timer_keyed_entry_table uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  timer_keyed_entry_table_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t make_word(input logic op, input logic [63:0] peer,
                                     input logic [7:0] level, input logic [15:0] bucket,
                                     input logic [31:0] fp, input logic [63:0] timer);
    return req_t'({op, peer, level, bucket, fp, timer});
  endfunction

  function automatic req_t random_word(input int add_pct);
    logic [63:0] key;
    key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
    return make_word(($urandom_range(99) < add_pct) ? OP_ADD : OP_REMOVE, {$urandom, $urandom},
                     8'($urandom), 16'($urandom), $urandom, key);
  endfunction

  task automatic send_word(input req_t w);
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? 150 : $urandom_range(0, 20);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int phase_left;
    int add_pct;
    rst        <= 1'b1;
    start      <= 1'b0;
    request    <= '0;
    sent       = 0;
    burst_left = 4;
    phase      = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, extreme field values, duplicate keys and misses.
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, '0));
    send_word(make_word(OP_ADD, '0, '0, '0, '0, '0));
    send_word(make_word(OP_ADD, '1, '1, '1, '1, '1));
    send_word(make_word(OP_ADD, 64'hA5A5_5A5A_0F0F_F0F0, 8'h5A, 16'hC33C, 32'h1234_5678, KEY_A));
    send_word(make_word(OP_ADD, 64'h5A5A_A5A5_F0F0_0F0F, 8'hA5, 16'h3CC3, 32'h8765_4321, KEY_A));
    send_word(make_word(OP_ADD, 64'h1, 8'h1, 16'h1, 32'h1, 64'h8000_0000_0000_0000));
    send_word(make_word(OP_REMOVE, '1, '1, '1, '1, KEY_A));
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, '1));
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, KEY_A));
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, KEY_A));
    send_word(make_word(OP_REMOVE, '1, '1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF));
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, 64'h8000_0000_0000_0000));
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, '0));
    send_word(make_word(OP_REMOVE, '0, '0, '0, '0, '0));

    // The first two phases fill the table past full and then send only removes to drain it.
    while (sent < ITEM_TOTAL) begin
      if (phase == 0) begin
        add_pct    = 100;
        phase_left = 72;
      end else if (phase == 1) begin
        add_pct    = 0;
        phase_left = 72;
      end else begin
        case ($urandom_range(2))
          0:       add_pct = 92;
          1:       add_pct = 50;
          default: add_pct = 12;
        endcase
        phase_left = $urandom_range(40, 160);
      end
      phase++;
      while (phase_left > 0 && sent < ITEM_TOTAL) begin
        send_word(random_word(add_pct));
        phase_left--;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
